// ===== hdl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// Holds the phase encoding, the queue entry and the configuration bundle.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package i2cm_pkg;

  // Packed widths of the stream payloads (padded to whole bytes).
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // Command codes carried in the action field.
  localparam logic [2:0] ACT_START    = 3'd0;
  localparam logic [2:0] ACT_STOP     = 3'd1;
  localparam logic [2:0] ACT_WRITE    = 3'd2;
  localparam logic [2:0] ACT_READ     = 3'd3;
  localparam logic [2:0] ACT_WAIT_ACK = 3'd4;

  // Sequencer phases, one-hot.
  typedef enum logic [22:0] {
    PH_IDLE = 23'h000001,
    PH_ST0  = 23'h000002,
    PH_ST1  = 23'h000004,
    PH_ST2  = 23'h000008,
    PH_ST3  = 23'h000010,
    PH_SP0  = 23'h000020,
    PH_SP1  = 23'h000040,
    PH_SP2  = 23'h000080,
    PH_WR0  = 23'h000100,
    PH_WR1  = 23'h000200,
    PH_WR2  = 23'h000400,
    PH_WR3  = 23'h000800,
    PH_RD0  = 23'h001000,
    PH_RD1  = 23'h002000,
    PH_RD2  = 23'h004000,
    PH_AK0  = 23'h008000,
    PH_AK1  = 23'h010000,
    PH_AK2  = 23'h020000,
    PH_AK3  = 23'h040000,
    PH_AK4  = 23'h080000,
    PH_WK0  = 23'h100000,
    PH_WK1  = 23'h200000,
    PH_WK2  = 23'h400000
  } phase_t;

  // One classified tick as it waits between front and back.
  typedef struct packed {
    logic       cmd_ok;      // a legal command was offered on this tick
    phase_t     start_ph;    // first phase of that command
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // Timing registers seen by the sequencer.
  typedef struct packed {
    logic [15:0] half_delay;
    logic [7:0]  tail_delay;
    logic [7:0]  ack_timeout;
  } cfg_t;

endpackage

// ===== hdl/i2cm_queue.sv =====
// Small FIFO of classified ticks between the front and the back.
// Depends on i2cm_pkg for the entry type.
module i2cm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  i2cm_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output i2cm_pkg::item_t pop_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  i2cm_pkg::item_t store_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign pop_item = store_r[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/i2cm_front.sv =====
// Input side of the I2C master bit engine: unpacks each tick and decodes its command.
// Depends on i2cm_pkg; feeds i2cm_queue.
module i2cm_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [i2cm_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output i2cm_pkg::item_t                q_item
);

  logic [2:0] action;

  assign action    = in_tdata[2:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Classify the offered command and pick the phase it starts in.
  always_comb begin
    q_item.write_byte = in_tdata[10:3];
    q_item.send_ack   = in_tdata[11];
    q_item.sda_in     = in_tdata[12];
    q_item.cmd_ok     = in_tuser;
    q_item.start_ph   = i2cm_pkg::PH_IDLE;
    case (action)
      i2cm_pkg::ACT_START:    q_item.start_ph = i2cm_pkg::PH_ST0;
      i2cm_pkg::ACT_STOP:     q_item.start_ph = i2cm_pkg::PH_SP0;
      i2cm_pkg::ACT_WRITE:    q_item.start_ph = i2cm_pkg::PH_WR0;
      i2cm_pkg::ACT_READ:     q_item.start_ph = i2cm_pkg::PH_RD0;
      i2cm_pkg::ACT_WAIT_ACK: q_item.start_ph = i2cm_pkg::PH_WK0;
      default:                q_item.cmd_ok   = 1'b0;
    endcase
  end

endmodule

// ===== hdl/i2cm_back.sv =====
// Phase sequencer of the I2C master bit engine plus the result register.
// Uses i2cm_pkg; takes ticks from i2cm_queue, one per cycle unless stalled.
module i2cm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  i2cm_pkg::cfg_t                  cfg,
  input  logic                            q_valid,
  input  i2cm_pkg::item_t                 q_item,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0] out_tdata
);

  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [15:0] delay_count_r, delay_count_nxt;
  logic [7:0]  poll_count_r, poll_count_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic        ack_choice_r, ack_choice_nxt;
  logic [7:0]  read_hold_r, read_hold_nxt;
  logic        ack_flag_r, ack_flag_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        sda_en_r, sda_en_nxt;
  logic        done_nxt;
  logic        enter;
  i2cm_pkg::phase_t enter_ph;
  logic [15:0] wait_ticks;
  logic        step;
  logic        out_valid_r;
  logic [i2cm_pkg::OUT_DATA_W-1:0] out_data_r;

  // A tick advances when one is queued and the result slot is free.
  assign step       = q_valid && (!out_valid_r || out_tready);
  assign q_pop      = step;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // One tick of the sequencer.
  always_comb begin
    phase_nxt       = phase_r;
    bit_count_nxt   = bit_count_r;
    delay_count_nxt = delay_count_r;
    poll_count_nxt  = poll_count_r;
    shift_byte_nxt  = shift_byte_r;
    ack_choice_nxt  = ack_choice_r;
    read_hold_nxt   = read_hold_r;
    ack_flag_nxt    = ack_flag_r;
    scl_nxt         = scl_r;
    sda_nxt         = sda_r;
    sda_en_nxt      = sda_en_r;
    done_nxt        = 1'b0;
    enter           = 1'b0;
    enter_ph        = i2cm_pkg::PH_IDLE;
    wait_ticks      = cfg.half_delay;

    if (phase_r == i2cm_pkg::PH_IDLE) begin
      // Launch a command.
      if (q_item.cmd_ok) begin
        bit_count_nxt  = 4'd0;
        ack_choice_nxt = q_item.send_ack;
        if (q_item.start_ph == i2cm_pkg::PH_WR0) begin
          shift_byte_nxt = q_item.write_byte;
        end
        enter    = 1'b1;
        enter_ph = q_item.start_ph;
      end
    end else if (phase_r == i2cm_pkg::PH_WK1) begin
      // Poll SDA with SCL high until the slave pulls it low or time runs out.
      if (!q_item.sda_in) begin
        ack_flag_nxt = 1'b1;
        enter        = 1'b1;
        enter_ph     = i2cm_pkg::PH_WK2;
      end else if (poll_count_r >= cfg.ack_timeout) begin
        ack_flag_nxt = 1'b0;
        enter        = 1'b1;
        enter_ph     = i2cm_pkg::PH_WK2;
      end else begin
        poll_count_nxt = poll_count_r + 8'd1;
      end
    end else if (delay_count_r != 16'd0) begin
      delay_count_nxt = delay_count_r - 16'd1;
    end else begin
      // Wait over: choose the following phase.
      enter = 1'b1;
      case (phase_r)
        i2cm_pkg::PH_ST0: enter_ph = i2cm_pkg::PH_ST1;
        i2cm_pkg::PH_ST1: enter_ph = i2cm_pkg::PH_ST2;
        i2cm_pkg::PH_ST2: enter_ph = i2cm_pkg::PH_ST3;
        i2cm_pkg::PH_SP0: enter_ph = i2cm_pkg::PH_SP1;
        i2cm_pkg::PH_SP1: enter_ph = i2cm_pkg::PH_SP2;
        i2cm_pkg::PH_WR0: enter_ph = i2cm_pkg::PH_WR1;
        i2cm_pkg::PH_WR1: enter_ph = i2cm_pkg::PH_WR2;
        i2cm_pkg::PH_WR2: begin
          shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
          bit_count_nxt  = bit_count_r + 4'd1;
          enter_ph = (bit_count_nxt >= 4'd8) ? i2cm_pkg::PH_WR3 : i2cm_pkg::PH_WR0;
        end
        i2cm_pkg::PH_RD0: enter_ph = i2cm_pkg::PH_RD1;
        i2cm_pkg::PH_RD1: begin
          shift_byte_nxt = {shift_byte_r[6:0], q_item.sda_in};
          bit_count_nxt  = bit_count_r + 4'd1;
          if (bit_count_nxt >= 4'd8) begin
            read_hold_nxt = shift_byte_nxt;
          end
          enter_ph = i2cm_pkg::PH_RD2;
        end
        i2cm_pkg::PH_RD2: begin
          enter_ph = (bit_count_r >= 4'd8) ? i2cm_pkg::PH_AK0 : i2cm_pkg::PH_RD1;
        end
        i2cm_pkg::PH_AK0: enter_ph = i2cm_pkg::PH_AK1;
        i2cm_pkg::PH_AK1: enter_ph = i2cm_pkg::PH_AK2;
        i2cm_pkg::PH_AK2: begin
          enter_ph = ack_choice_r ? i2cm_pkg::PH_AK3 : i2cm_pkg::PH_AK4;
        end
        i2cm_pkg::PH_AK3: enter_ph = i2cm_pkg::PH_AK4;
        i2cm_pkg::PH_WK0: enter_ph = i2cm_pkg::PH_WK1;
        default: begin
          // Last phase of a command: finish.
          enter           = 1'b0;
          phase_nxt       = i2cm_pkg::PH_IDLE;
          delay_count_nxt = 16'd0;
          done_nxt        = 1'b1;
        end
      endcase
    end

    // Entering a phase sets its pins and loads its wait.
    if (enter) begin
      phase_nxt = enter_ph;
      case (enter_ph)
        i2cm_pkg::PH_ST1: begin
          sda_en_nxt = 1'b1;
          sda_nxt    = 1'b1;
          scl_nxt    = 1'b1;
        end
        i2cm_pkg::PH_ST2: sda_nxt = 1'b0;
        i2cm_pkg::PH_ST3: begin
          scl_nxt    = 1'b0;
          wait_ticks = 16'd0;
        end
        i2cm_pkg::PH_SP0: begin
          sda_nxt    = 1'b0;
          sda_en_nxt = 1'b1;
        end
        i2cm_pkg::PH_SP1: scl_nxt = 1'b1;
        i2cm_pkg::PH_SP2: sda_nxt = 1'b1;
        i2cm_pkg::PH_WR0: begin
          sda_en_nxt = 1'b1;
          scl_nxt    = 1'b0;
        end
        i2cm_pkg::PH_WR1: sda_nxt = shift_byte_nxt[7];
        i2cm_pkg::PH_WR2: scl_nxt = 1'b1;
        i2cm_pkg::PH_WR3: begin
          scl_nxt    = 1'b0;
          sda_en_nxt = 1'b0;
          wait_ticks = 16'd0;
        end
        i2cm_pkg::PH_RD0: begin
          sda_en_nxt = 1'b0;
          scl_nxt    = 1'b0;
        end
        i2cm_pkg::PH_RD1: scl_nxt = 1'b1;
        i2cm_pkg::PH_RD2: scl_nxt = 1'b0;
        i2cm_pkg::PH_AK0: begin
          sda_en_nxt = 1'b1;
          sda_nxt    = !ack_choice_nxt;
        end
        i2cm_pkg::PH_AK1: scl_nxt = 1'b1;
        i2cm_pkg::PH_AK2: scl_nxt = 1'b0;
        i2cm_pkg::PH_AK3: sda_nxt = 1'b1;
        i2cm_pkg::PH_AK4: wait_ticks = {8'd0, cfg.tail_delay};
        i2cm_pkg::PH_WK0: sda_en_nxt = 1'b0;
        i2cm_pkg::PH_WK1: begin
          scl_nxt        = 1'b1;
          poll_count_nxt = 8'd0;
          wait_ticks     = 16'd0;
        end
        i2cm_pkg::PH_WK2: begin
          scl_nxt    = 1'b0;
          wait_ticks = {8'd0, cfg.tail_delay};
        end
        i2cm_pkg::PH_ST0: wait_ticks = cfg.half_delay;
        default: wait_ticks = 16'd0;
      endcase
      delay_count_nxt = wait_ticks;
    end
  end

  // Sequencer state advances only on a tick taken from the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= i2cm_pkg::PH_IDLE;
      bit_count_r   <= 4'd0;
      delay_count_r <= 16'd0;
      poll_count_r  <= 8'd0;
      shift_byte_r  <= 8'd0;
      ack_choice_r  <= 1'b0;
      read_hold_r   <= 8'd0;
      ack_flag_r    <= 1'b0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      sda_en_r      <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      bit_count_r   <= bit_count_nxt;
      delay_count_r <= delay_count_nxt;
      poll_count_r  <= poll_count_nxt;
      shift_byte_r  <= shift_byte_nxt;
      ack_choice_r  <= ack_choice_nxt;
      read_hold_r   <= read_hold_nxt;
      ack_flag_r    <= ack_flag_nxt;
      scl_r         <= scl_nxt;
      sda_r         <= sda_nxt;
      sda_en_r      <= sda_en_nxt;
    end
  end

  // Result register: holds a finished tick until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {2'b00, ack_flag_nxt, read_hold_nxt, done_nxt,
                     (phase_nxt != i2cm_pkg::PH_IDLE), sda_en_nxt, sda_nxt, scl_nxt};
    end
  end

  // A legal command taken while idle always leaves idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == i2cm_pkg::PH_IDLE) && q_item.cmd_ok |=> phase_r != i2cm_pkg::PH_IDLE)
    else $error("command accepted while idle did not start a sequence");

  // A sequence finishes only from one of the closing phases.
  assert property (@(posedge clk) disable iff (!rst_n)
    step && done_nxt |-> (phase_r == i2cm_pkg::PH_ST3) || (phase_r == i2cm_pkg::PH_SP2) ||
      (phase_r == i2cm_pkg::PH_WR3) || (phase_r == i2cm_pkg::PH_AK4) ||
      (phase_r == i2cm_pkg::PH_WK2))
    else $error("sequence finished from a non-closing phase");

  // The bit counter never runs past one byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= 4'd8)
    else $error("bit counter past eight");

  // Polling stops once the timeout count is reached.
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2cm_pkg::PH_WK1 |-> poll_count_r <= cfg.ack_timeout)
    else $error("acknowledge poll ran past its timeout");

endmodule

// ===== hdl/i2c_master_bit_engine_core.sv =====
// Top level of the I2C master bit engine: timing registers on an APB-style port,
// tick front end, tick queue and phase sequencer.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
//
// Usage: every transfer on the in_ channel is one tick of the bus sequencer. It carries
// the sampled SDA level and, flagged by in_tuser, a command (start, stop, write byte,
// read byte with ACK or NACK, wait for ACK) that is taken only when the engine is idle;
// a command offered while busy, or with an undefined action code, is dropped.
// Every input tick yields exactly one out_ transfer with the SCL level, the SDA level and
// drive enable, busy, done, the last byte read and the last acknowledge result.
// Throughput: one tick per clock cycle while out_tready is high. An accepted tick is
// first written into the queue, then the sequencer step loads its result into the
// result register. Stalls: while out_tready is low the result register holds; the
// queue of QUEUE_DEPTH ticks keeps taking input until full, then in_tready drops.
// Reset (rst_n low, synchronous): sequencer idle with SCL high and SDA released, queue
// empty, half_delay 10, tail_delay 80, ack_timeout 250.
// Registers (byte address): half_delay 0x0, tail_delay 0x4, ack_timeout 0x8; write
// them only while the engine is idle.
module i2c_master_bit_engine_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input ticks. tdata: action[2:0], write_byte[10:3], send_ack[11], sda_in[12], zero.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [i2cm_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: cmd_valid[0].
  input  logic        in_tuser,
  // Results. tdata: scl_level[0], sda_level[1], sda_drive_enable[2], busy_res[3],
  // done_res[4], read_data[12:5], ack_seen[13], zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [1:0] REG_HALF_DELAY  = 2'd0;
  localparam logic [1:0] REG_TAIL_DELAY  = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

  i2cm_pkg::cfg_t  cfg_r;
  i2cm_pkg::item_t push_item;
  i2cm_pkg::item_t pop_item;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_nonempty;
  logic            cfg_wr;
  logic [1:0]      reg_index;

  assign cfg_pready = 1'b1;
  assign reg_index  = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_delay  <= 16'd10;
      cfg_r.tail_delay  <= 8'd80;
      cfg_r.ack_timeout <= 8'd250;
    end else if (cfg_wr) begin
      case (reg_index)
        REG_HALF_DELAY:  cfg_r.half_delay  <= cfg_pwdata[15:0];
        REG_TAIL_DELAY:  cfg_r.tail_delay  <= cfg_pwdata[7:0];
        REG_ACK_TIMEOUT: cfg_r.ack_timeout <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_index)
      REG_HALF_DELAY:  cfg_prdata = {16'd0, cfg_r.half_delay};
      REG_TAIL_DELAY:  cfg_prdata = {24'd0, cfg_r.tail_delay};
      REG_ACK_TIMEOUT: cfg_prdata = {24'd0, cfg_r.ack_timeout};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  i2cm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (pop_item)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_nonempty),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/tb_i2c_master_bit_engine_core.sv =====
// Self-checking testbench for the I2C master bit engine core.
// Drives ticks through the stream ports, sets timing registers over APB and checks every
// result against an in-bench model of the phase sequencer. Depends on i2cm_pkg and the RTL.
module tb_i2c_master_bit_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes and undefined action codes.
  localparam int REG_HALF = 0;
  localparam int REG_TAIL = 1;
  localparam int REG_TMO  = 2;
  localparam logic [2:0] ACT_UNDEF_LO  = 3'd5;
  localparam logic [2:0] ACT_UNDEF_MID = 3'd6;
  localparam logic [2:0] ACT_UNDEF_HI  = 3'd7;

  // How the sampled SDA line behaves while a command runs.
  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND, SDA_ACK_AT} sda_mode_t;

  // One result tick, laid out as out_tdata.
  typedef struct packed {
    logic [1:0] pad;
    logic       ack;
    logic [7:0] rdata;
    logic       done;
    logic       busy;
    logic       oe;
    logic       sda;
    logic       scl;
  } res_t;

  typedef struct packed {
    logic       cmd;
    logic [2:0] act;
    logic [7:0] wb;
    logic       sa;
    sda_mode_t  mode;
    logic [9:0] ack_at;
    logic       noise;
    logic       chk;
    res_t       want;
  } dir_row_t;

  localparam res_t R_IDLE  = '{pad: 2'b0, ack: 1'b0, rdata: 8'h00, done: 1'b0, busy: 1'b0,
                               oe: 1'b0, sda: 1'b1, scl: 1'b1};
  localparam res_t R_START = '{pad: 2'b0, ack: 1'b0, rdata: 8'h00, done: 1'b0, busy: 1'b1,
                               oe: 1'b0, sda: 1'b1, scl: 1'b1};

  // Directed commands; the first rows run from reset so their first tick is known.
  // From row DIR_SHORT_FROM on, short delays keep the bus sequences brief.
  localparam int DIR_ROWS = 19;
  localparam int DIR_SHORT_FROM = 5;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b0, i2cm_pkg::ACT_START,    8'h00, 1'b0, SDA_HIGH,   10'd0, 1'b0, 1'b1, R_IDLE},
    '{1'b1, ACT_UNDEF_LO,           8'h00, 1'b0, SDA_HIGH,   10'd0, 1'b0, 1'b1, R_IDLE},
    '{1'b1, ACT_UNDEF_HI,           8'hFF, 1'b1, SDA_LOW,    10'd0, 1'b0, 1'b1, R_IDLE},
    '{1'b1, ACT_UNDEF_MID,          8'h5A, 1'b0, SDA_HIGH,   10'd0, 1'b0, 1'b1, R_IDLE},
    '{1'b1, i2cm_pkg::ACT_START,    8'h00, 1'b0, SDA_HIGH,   10'd0, 1'b0, 1'b1, R_START},
    '{1'b1, i2cm_pkg::ACT_WRITE,    8'hFF, 1'b1, SDA_HIGH,   10'd0, 1'b1, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH,   10'd0, 1'b0, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_WRITE,    8'h00, 1'b0, SDA_LOW,    10'd0, 1'b0, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_WAIT_ACK, 8'hFF, 1'b1, SDA_ACK_AT, 10'd6, 1'b1, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_WAIT_ACK, 8'h00, 1'b0, SDA_LOW,    10'd0, 1'b0, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_READ,     8'h00, 1'b1, SDA_HIGH,   10'd0, 1'b0, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_READ,     8'hFF, 1'b0, SDA_LOW,    10'd0, 1'b1, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_READ,     8'h00, 1'b1, SDA_RAND,   10'd0, 1'b0, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_WRITE,    8'hA5, 1'b0, SDA_RAND,   10'd0, 1'b1, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_WRITE,    8'h5A, 1'b1, SDA_RAND,   10'd0, 1'b0, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_STOP,     8'h00, 1'b0, SDA_HIGH,   10'd0, 1'b0, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_START,    8'hFF, 1'b1, SDA_LOW,    10'd0, 1'b1, 1'b0, '0},
    '{1'b1, i2cm_pkg::ACT_STOP,     8'h00, 1'b0, SDA_RAND,   10'd0, 1'b1, 1'b0, '0},
    '{1'b0, i2cm_pkg::ACT_WRITE,    8'h81, 1'b1, SDA_LOW,    10'd0, 1'b0, 1'b0, '0}
  };

  // Register settings for the random phases and the ticks spent in each.
  // The all-ones setting is only written and read back.
  localparam int SETS = 6;
  localparam int unsigned SET_HALF  [SETS] = '{1, 0, 65535, 3, 0, 2};
  localparam int unsigned SET_TAIL  [SETS] = '{0, 0, 255, 7, 0, 3};
  localparam int unsigned SET_TMO   [SETS] = '{1, 3, 255, 12, 0, 1};
  localparam int unsigned SET_TICKS [SETS] = '{120, 120, 0, 120, 120, 120};

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [i2cm_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [i2cm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Engine model state, at its reset values.
  i2cm_pkg::phase_t pr_phase = i2cm_pkg::PH_IDLE;
  logic [3:0]  bit_cnt = '0;
  logic [15:0] dly = '0;
  logic [7:0]  poll = '0;
  logic [7:0]  shreg = '0;
  logic        ack_sel = 1'b0;
  logic [7:0]  rd_hold = '0;
  logic        ack_hit = 1'b0;
  logic        scl_o = 1'b1;
  logic        sda_o = 1'b1;
  logic        oe_o = 1'b0;
  logic [15:0] m_half = 16'd10;
  logic [7:0]  m_tail = 8'd80;
  logic [7:0]  m_tmo = 8'd250;

  res_t want_ticks [$];
  int   mismatches = 0;
  int   cmd_taken = 0;
  int   ticks_sent = 0;
  int   burst_left = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  logic [7:0] rx_tick = '0;

  i2c_master_bit_engine_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply the pins of a phase on entry and load its wait.
  function automatic void enter_phase(i2cm_pkg::phase_t p);
    logic [15:0] w;
    w = m_half;
    pr_phase = p;
    case (p)
      i2cm_pkg::PH_ST0: ;
      i2cm_pkg::PH_ST1: begin
        oe_o = 1'b1;
        sda_o = 1'b1;
        scl_o = 1'b1;
      end
      i2cm_pkg::PH_ST2: sda_o = 1'b0;
      i2cm_pkg::PH_ST3: begin
        scl_o = 1'b0;
        w = '0;
      end
      i2cm_pkg::PH_SP0: begin
        sda_o = 1'b0;
        oe_o = 1'b1;
      end
      i2cm_pkg::PH_SP1: scl_o = 1'b1;
      i2cm_pkg::PH_SP2: sda_o = 1'b1;
      i2cm_pkg::PH_WR0: begin
        oe_o = 1'b1;
        scl_o = 1'b0;
      end
      i2cm_pkg::PH_WR1: sda_o = shreg[7];
      i2cm_pkg::PH_WR2: scl_o = 1'b1;
      i2cm_pkg::PH_WR3: begin
        scl_o = 1'b0;
        oe_o = 1'b0;
        w = '0;
      end
      i2cm_pkg::PH_RD0: begin
        oe_o = 1'b0;
        scl_o = 1'b0;
      end
      i2cm_pkg::PH_RD1: scl_o = 1'b1;
      i2cm_pkg::PH_RD2: scl_o = 1'b0;
      i2cm_pkg::PH_AK0: begin
        oe_o = 1'b1;
        sda_o = !ack_sel;
      end
      i2cm_pkg::PH_AK1: scl_o = 1'b1;
      i2cm_pkg::PH_AK2: scl_o = 1'b0;
      i2cm_pkg::PH_AK3: sda_o = 1'b1;
      i2cm_pkg::PH_AK4: w = {8'h00, m_tail};
      i2cm_pkg::PH_WK0: oe_o = 1'b0;
      i2cm_pkg::PH_WK1: begin
        scl_o = 1'b1;
        poll = '0;
        w = '0;
      end
      i2cm_pkg::PH_WK2: begin
        scl_o = 1'b0;
        w = {8'h00, m_tail};
      end
      default: w = '0;
    endcase
    dly = w;
  endfunction

  // Phase that follows once the wait has run out; shifts data bits on the way.
  function automatic i2cm_pkg::phase_t advance_phase(logic sda);
    case (pr_phase)
      i2cm_pkg::PH_ST0: return i2cm_pkg::PH_ST1;
      i2cm_pkg::PH_ST1: return i2cm_pkg::PH_ST2;
      i2cm_pkg::PH_ST2: return i2cm_pkg::PH_ST3;
      i2cm_pkg::PH_SP0: return i2cm_pkg::PH_SP1;
      i2cm_pkg::PH_SP1: return i2cm_pkg::PH_SP2;
      i2cm_pkg::PH_WR0: return i2cm_pkg::PH_WR1;
      i2cm_pkg::PH_WR1: return i2cm_pkg::PH_WR2;
      i2cm_pkg::PH_WR2: begin
        shreg = {shreg[6:0], 1'b0};
        bit_cnt = bit_cnt + 4'd1;
        return (bit_cnt >= 4'd8) ? i2cm_pkg::PH_WR3 : i2cm_pkg::PH_WR0;
      end
      i2cm_pkg::PH_RD0: return i2cm_pkg::PH_RD1;
      i2cm_pkg::PH_RD1: begin
        // The bit is taken on the tick that drops SCL.
        shreg = {shreg[6:0], sda};
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) rd_hold = shreg;
        return i2cm_pkg::PH_RD2;
      end
      i2cm_pkg::PH_RD2: return (bit_cnt >= 4'd8) ? i2cm_pkg::PH_AK0 : i2cm_pkg::PH_RD1;
      i2cm_pkg::PH_AK0: return i2cm_pkg::PH_AK1;
      i2cm_pkg::PH_AK1: return i2cm_pkg::PH_AK2;
      i2cm_pkg::PH_AK2: return ack_sel ? i2cm_pkg::PH_AK3 : i2cm_pkg::PH_AK4;
      i2cm_pkg::PH_AK3: return i2cm_pkg::PH_AK4;
      i2cm_pkg::PH_WK0: return i2cm_pkg::PH_WK1;
      default: return i2cm_pkg::PH_IDLE;
    endcase
  endfunction

  // Advance the engine model by one tick and return the pins and status it shows.
  function automatic res_t step_engine(logic cmd, logic [2:0] act, logic [7:0] wb, logic sa,
                                       logic sda);
    res_t r;
    logic fin;
    i2cm_pkg::phase_t nx;
    fin = 1'b0;
    if (pr_phase == i2cm_pkg::PH_IDLE) begin
      // Commands are taken only from idle, and only the defined ones.
      if (cmd && act <= i2cm_pkg::ACT_WAIT_ACK) begin
        cmd_taken++;
        bit_cnt = '0;
        ack_sel = sa;
        if (act == i2cm_pkg::ACT_WRITE) shreg = wb;
        case (act)
          i2cm_pkg::ACT_START: enter_phase(i2cm_pkg::PH_ST0);
          i2cm_pkg::ACT_STOP: enter_phase(i2cm_pkg::PH_SP0);
          i2cm_pkg::ACT_WRITE: enter_phase(i2cm_pkg::PH_WR0);
          i2cm_pkg::ACT_READ: enter_phase(i2cm_pkg::PH_RD0);
          default: enter_phase(i2cm_pkg::PH_WK0);
        endcase
      end
    end else if (pr_phase == i2cm_pkg::PH_WK1) begin
      // Poll for the slave pulling SDA low, bounded by the timeout register.
      if (!sda) begin
        ack_hit = 1'b1;
        enter_phase(i2cm_pkg::PH_WK2);
      end else if (poll >= m_tmo) begin
        ack_hit = 1'b0;
        enter_phase(i2cm_pkg::PH_WK2);
      end else begin
        poll = poll + 8'd1;
      end
    end else if (dly != '0) begin
      dly = dly - 16'd1;
    end else begin
      nx = advance_phase(sda);
      if (nx == i2cm_pkg::PH_IDLE) begin
        pr_phase = i2cm_pkg::PH_IDLE;
        dly = '0;
        fin = 1'b1;
      end else begin
        enter_phase(nx);
      end
    end
    r = '0;
    r.scl = scl_o;
    r.sda = sda_o;
    r.oe = oe_o;
    r.busy = (pr_phase != i2cm_pkg::PH_IDLE);
    r.done = fin;
    r.rdata = rd_hold;
    r.ack = ack_hit;
    return r;
  endfunction

  // Offer one tick on the input stream; the sender idles between bursts unless tx_calm.
  task automatic send_tick(logic cmd, logic [2:0] act, logic [7:0] wb, logic sa, logic sda,
                           logic chk, res_t want);
    res_t r;
    if (burst_left == 0) begin
      if (!tx_calm) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {3'b000, sda, sa, wb, act};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
    r = step_engine(cmd, act, wb, sa, sda);
    want_ticks.push_back(chk ? want : r);
  endtask

  // Offer a command, then keep ticking until the engine is idle again.
  task automatic run_cmd(logic cmd, logic [2:0] act, logic [7:0] wb, logic sa,
                         sda_mode_t mode, int ack_at, logic noise, logic chk, res_t want);
    int n;
    logic s;
    n = 0;
    do begin
      case (mode)
        SDA_LOW: s = 1'b0;
        SDA_HIGH: s = 1'b1;
        SDA_RAND: s = 1'($urandom_range(0, 1));
        default: s = (n < ack_at);
      endcase
      if (n == 0) begin
        send_tick(cmd, act, wb, sa, s, chk, want);
      end else begin
        // Commands offered while busy must be dropped.
        send_tick(noise && $urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s, 1'b0, '0);
      end
      n++;
    end while (pr_phase != i2cm_pkg::PH_IDLE);
  endtask

  // Bring the engine to idle and wait for every result to arrive.
  task automatic quiesce();
    while (pr_phase != i2cm_pkg::PH_IDLE)
      send_tick(1'b0, i2cm_pkg::ACT_START, 8'h00, 1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
    in_tvalid <= 1'b0;
    while (want_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, then read it back.
  task automatic cfg_set(int idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(idx * 4);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_HALF: m_half = val[15:0];
      REG_TAIL: m_tail = val[7:0];
      default: m_tmo = val[7:0];
    endcase
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== val) begin
      mismatches++;
      $display("%0t: register %0d expected %0h, got %0h", $time, idx, val, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Receiver: stalls in short blocks on a fixed beat plus random cycles, unless rx_calm.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_calm) out_tready <= 1'b1;
    else out_tready <= (rx_tick[4:2] != 3'd5) && ($urandom_range(0, 5) != 0);
  end

  // Compare every result transfer with the oldest expected tick.
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata);
      if (want_ticks.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, got %0h", $time, out_tdata);
      end else begin
        want = want_ticks.pop_front();
        check_field("scl_level", want.scl, got.scl);
        check_field("sda_level", want.sda, got.sda);
        check_field("sda_drive_enable", want.oe, got.oe);
        check_field("busy", want.busy, got.busy);
        check_field("done", want.done, got.done);
        check_field("read_data", want.rdata, got.rdata);
        check_field("ack_seen", want.ack, got.ack);
      end
    end
  end

  initial begin
    int p;
    int k;
    int nd;
    int goal;
    logic [7:0] addr;
    logic [15:0] hd;
    logic [7:0] tl;
    logic [7:0] tm;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands: the first rows at the reset register values, the rest with
    // short delays.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_SHORT_FROM) begin
        quiesce();
        cfg_set(REG_HALF, 32'd1);
        cfg_set(REG_TAIL, 32'd2);
        cfg_set(REG_TMO, 32'd8);
      end
      run_cmd(DIR_TAB[i].cmd, DIR_TAB[i].act, DIR_TAB[i].wb, DIR_TAB[i].sa, DIR_TAB[i].mode,
              DIR_TAB[i].ack_at, DIR_TAB[i].noise, DIR_TAB[i].chk, DIR_TAB[i].want);
    end

    // Random bus transactions under several register settings.
    for (p = 0; p < SETS; p++) begin
      quiesce();
      hd = 16'(SET_HALF[p]);
      tl = 8'(SET_TAIL[p]);
      tm = 8'(SET_TMO[p]);
      if (p == 4) begin
        hd = 16'($urandom_range(1, 4));
        tl = 8'($urandom_range(0, 6));
        tm = 8'($urandom_range(1, 10));
      end
      cfg_set(REG_HALF, {16'h0000, hd});
      cfg_set(REG_TAIL, {24'h000000, tl});
      cfg_set(REG_TMO, {24'h000000, tm});
      goal = ticks_sent + int'(SET_TICKS[p]);
      while (ticks_sent < goal) begin
        tx_calm = ($urandom_range(0, 7) == 0);
        rx_calm = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) < 8) begin
          // Start, address with acknowledge, a few data bytes, usually a stop.
          addr = 8'($urandom_range(0, 255));
          run_cmd(1'b1, i2cm_pkg::ACT_START, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), SDA_RAND, 0, 1'($urandom_range(0, 1)), 1'b0, '0);
          run_cmd(1'b1, i2cm_pkg::ACT_WRITE, addr, 1'($urandom_range(0, 1)), SDA_RAND, 0,
                  1'($urandom_range(0, 1)), 1'b0, '0);
          run_cmd(1'b1, i2cm_pkg::ACT_WAIT_ACK, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), SDA_ACK_AT,
                  $urandom_range(0, m_half + m_tmo + 8), 1'($urandom_range(0, 1)), 1'b0, '0);
          nd = $urandom_range(0, 3);
          for (k = 0; k < nd; k++) begin
            if (addr[0]) begin
              // The last byte of a read is answered with a NACK.
              run_cmd(1'b1, i2cm_pkg::ACT_READ, 8'($urandom_range(0, 255)), (k != nd - 1),
                      SDA_RAND, 0, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
              run_cmd(1'b1, i2cm_pkg::ACT_WRITE, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), SDA_RAND, 0, 1'($urandom_range(0, 1)),
                      1'b0, '0);
              run_cmd(1'b1, i2cm_pkg::ACT_WAIT_ACK, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), SDA_ACK_AT,
                      $urandom_range(0, m_half + m_tmo + 8), 1'($urandom_range(0, 1)),
                      1'b0, '0);
            end
          end
          if ($urandom_range(0, 3) != 0)
            run_cmd(1'b1, i2cm_pkg::ACT_STOP, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), SDA_RAND, 0, 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          // Loose command of any code, defined or not.
          run_cmd($urandom_range(0, 3) != 0, 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RAND, 0, 1'b1,
                  1'b0, '0);
        end
      end
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    quiesce();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && want_ticks.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== i2c_master_bit_engine_core.f =====
hdl/i2cm_pkg.sv
hdl/i2cm_queue.sv
hdl/i2cm_front.sv
hdl/i2cm_back.sv
hdl/i2c_master_bit_engine_core.sv
dv/tb_i2c_master_bit_engine_core.sv
